// File: rtl/hcd_pkg.sv
`timescale 1ns / 1ps

package hcd_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_HS_FIRST   = 3'd0;
  localparam logic [2:0] CFG_HS_REPLY   = 3'd1;
  localparam logic [2:0] CFG_HS_THIRD   = 3'd2;
  localparam logic [2:0] CFG_CMD_COUNT  = 3'd3;
  localparam logic [2:0] CFG_CMD_LENGTHS = 3'd4;

  localparam logic [3:0] CMD_COUNT_RESET = 4'd8;

  // length table: eight 6-bit entries
  localparam int LEN_W      = 6;
  localparam int NUM_CODES  = 8;

  // job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic             is_frame;
    logic [7:0]       reply;
    logic [2:0]       cmd;
    logic [LEN_W-1:0] len;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

endpackage

// File: rtl/hcd_front.sv
`timescale 1ns / 1ps

module hcd_front #(
  parameter int MAX_PAYLOAD  = 32,
  parameter int MAX_COMMANDS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [47:0]     cfg_wdata,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  output logic            q_push,
  output hcd_pkg::job_t   q_wdata,
  input  logic            q_ready,
  output hcd_pkg::mem_wr_t mem_wr,
  input  logic            frame_done
);
  import hcd_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_FIRST,
    PH_WAIT_THIRD,
    PH_LINK_UP
  } phase_t;

  logic [7:0]           hs_first_r;
  logic [7:0]           hs_reply_r;
  logic [7:0]           hs_third_r;
  logic [3:0]           cmd_count_r;
  logic [LEN_W*NUM_CODES-1:0] cmd_lengths_r;

  phase_t               phase_r, phase_nxt;
  logic                 in_frame_r, in_frame_nxt;
  logic [2:0]           cur_cmd_r, cur_cmd_nxt;
  logic [LEN_W-1:0]     pay_count_r, pay_count_nxt;
  logic                 busy_r, busy_nxt;

  logic                 accept;
  logic [3:0]           limit;
  logic [LEN_W-1:0]     len_raw;
  logic [LEN_W-1:0]     frame_len;
  logic [LEN_W-1:0]     pay_inc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_first_r    <= '0;
      hs_reply_r    <= '0;
      hs_third_r    <= '0;
      cmd_count_r   <= CMD_COUNT_RESET;
      cmd_lengths_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HS_FIRST:    hs_first_r    <= cfg_wdata[7:0];
        CFG_HS_REPLY:    hs_reply_r    <= cfg_wdata[7:0];
        CFG_HS_THIRD:    hs_third_r    <= cfg_wdata[7:0];
        CFG_CMD_COUNT:   cmd_count_r   <= cfg_wdata[3:0];
        CFG_CMD_LENGTHS: cmd_lengths_r <= cfg_wdata[LEN_W*NUM_CODES-1:0];
        default: ;
      endcase
    end
  end

  // hold input off while the job queue is full or a frame replay is pending
  assign in_tready = q_ready && !busy_r;
  assign accept    = in_tvalid && in_tready;

  // command limit and clamped payload length
  assign limit   = (cmd_count_r > 4'(MAX_COMMANDS)) ? 4'(MAX_COMMANDS) : cmd_count_r;
  assign len_raw = cmd_lengths_r[LEN_W*cur_cmd_r +: LEN_W];
  always_comb begin
    if (len_raw == '0) begin
      frame_len = LEN_W'(1);
    end else if ({1'b0, len_raw} > (LEN_W+1)'(MAX_PAYLOAD)) begin
      frame_len = LEN_W'(MAX_PAYLOAD);
    end else begin
      frame_len = len_raw;
    end
  end
  assign pay_inc = pay_count_r + LEN_W'(1);

  // handshake and framing
  always_comb begin
    phase_nxt     = phase_r;
    in_frame_nxt  = in_frame_r;
    cur_cmd_nxt   = cur_cmd_r;
    pay_count_nxt = pay_count_r;
    busy_nxt      = busy_r;
    q_push        = 1'b0;
    q_wdata       = '0;
    mem_wr        = '0;
    if (accept) begin
      case (phase_r)
        PH_WAIT_FIRST: begin
          if (in_tdata == hs_first_r) begin
            phase_nxt        = PH_WAIT_THIRD;
            q_push           = 1'b1;
            q_wdata.is_frame = 1'b0;
            q_wdata.reply    = hs_reply_r;
          end
        end
        PH_WAIT_THIRD: begin
          phase_nxt = (in_tdata == hs_third_r) ? PH_LINK_UP : PH_WAIT_FIRST;
        end
        PH_LINK_UP: begin
          if (!in_frame_r) begin
            if (in_tdata < {4'd0, limit}) begin
              cur_cmd_nxt   = in_tdata[2:0];
              in_frame_nxt  = 1'b1;
              pay_count_nxt = '0;
            end
          end else begin
            mem_wr.en     = 1'b1;
            mem_wr.addr   = pay_count_r;
            mem_wr.data   = in_tdata;
            pay_count_nxt = pay_inc;
            if (pay_inc >= frame_len) begin
              q_push           = 1'b1;
              q_wdata.is_frame = 1'b1;
              q_wdata.cmd      = cur_cmd_r;
              q_wdata.len      = frame_len;
              in_frame_nxt     = 1'b0;
              pay_count_nxt    = '0;
              busy_nxt         = 1'b1;
            end
          end
        end
        default: phase_nxt = PH_WAIT_FIRST;
      endcase
    end
    if (frame_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT_FIRST;
      in_frame_r  <= 1'b0;
      cur_cmd_r   <= '0;
      pay_count_r <= '0;
      busy_r      <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      in_frame_r  <= in_frame_nxt;
      cur_cmd_r   <= cur_cmd_nxt;
      pay_count_r <= pay_count_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule

// File: rtl/hcd_queue.sv
`timescale 1ns / 1ps

module hcd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hcd_pkg::job_t wdata,
  output logic          ready,
  input  logic          pop,
  output hcd_pkg::job_t rdata,
  output logic          valid
);
  import hcd_pkg::*;

  job_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign ready   = (count_r != Q_CNT_W'(Q_DEPTH));
  assign valid   = (count_r != '0);
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign rdata   = entry_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/hcd_back.sv
`timescale 1ns / 1ps

module hcd_back #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hcd_pkg::mem_wr_t mem_wr,
  input  logic             q_valid,
  input  hcd_pkg::job_t    q_rdata,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,
  output logic             out_tuser,
  output logic             out_tlast,
  output logic             frame_done
);
  import hcd_pkg::*;

  localparam int IDXW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SEND
  } state_t;

  logic [7:0]       store [MAX_PAYLOAD];
  logic [7:0]       rd_data_r;

  state_t           state_r;
  logic             kind_r;
  logic [7:0]       reply_r;
  logic [2:0]       cmd_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] idx_r;
  logic [LEN_W-1:0] idx_inc;
  logic             last_w;
  logic [7:0]       byte_w;

  // payload store, registered read
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      store[mem_wr.addr[IDXW-1:0]] <= mem_wr.data;
    end
    if (state_r == S_FETCH) begin
      rd_data_r <= store[idx_r[IDXW-1:0]];
    end
  end

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign idx_inc    = idx_r + LEN_W'(1);
  assign last_w     = !kind_r || (idx_inc == len_r);
  assign out_tvalid = (state_r == S_SEND);
  assign frame_done = (state_r == S_SEND) && out_tready && kind_r && last_w;
  assign byte_w     = kind_r ? rd_data_r : reply_r;

  // beat fields: byte, code, position, link_up
  assign out_tdata = {7'd0, kind_r, idx_r[4:0], cmd_r, byte_w};
  assign out_tuser = kind_r;
  assign out_tlast = last_w;

  // replay sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= 1'b0;
      reply_r <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      idx_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            kind_r  <= q_rdata.is_frame;
            reply_r <= q_rdata.reply;
            idx_r   <= '0;
            if (q_rdata.is_frame) begin
              cmd_r   <= q_rdata.cmd;
              len_r   <= q_rdata.len;
              state_r <= S_FETCH;
            end else begin
              cmd_r   <= '0;
              len_r   <= LEN_W'(1);
              state_r <= S_SEND;
            end
          end
        end
        S_FETCH: begin
          state_r <= S_SEND;
        end
        S_SEND: begin
          if (out_tready) begin
            if (last_w) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_inc;
              state_r <= S_FETCH;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/handshake_command_deframer.sv
`timescale 1ns / 1ps

// Handshake command deframer. Received bytes enter on the in_ stream, one
// beat per byte, each taken while in_tready is high. Until the link is
// up a three-byte handshake runs: the opening byte queues one reply beat
// (tuser 0), the third byte brings the link up, and any wrong byte restarts
// it. After that each frame is a command code and a payload of table length;
// the payload is written into an internal store and, on its last byte, a
// replay engine behind a two-entry job queue sends it out as a run of beats
// (tuser 1, tlast on the final one). Each payload beat passes through the
// replay engine as a store read, then a present; the input stream is held
// off from the last payload byte until the replay's final beat is taken,
// since the store has one write and one read port. Reply beats do not hold
// off input. The store needs no clearing after reset.
module handshake_command_deframer #(
  parameter int MAX_PAYLOAD  = 32,
  parameter int MAX_COMMANDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  // received bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [10:8] cmd_code,
                                  // [15:11] byte_pos, [16] link_up
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast
);
  import hcd_pkg::*;

  logic    q_push;
  job_t    q_wdata;
  logic    q_ready;
  logic    q_pop;
  job_t    q_rdata;
  logic    q_valid;
  mem_wr_t mem_wr;
  logic    frame_done;

  // byte intake, handshake and framing
  hcd_front #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .MAX_COMMANDS (MAX_COMMANDS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_push     (q_push),
    .q_wdata    (q_wdata),
    .q_ready    (q_ready),
    .mem_wr     (mem_wr),
    .frame_done (frame_done)
  );

  // job queue
  hcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .ready (q_ready),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  // reply and payload replay
  hcd_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mem_wr     (mem_wr),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .frame_done (frame_done)
  );

`ifndef SYNTHESIS
  // a reply is a single beat and never claims the link
  a_reply_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && !out_tdata[16])
    else $error("reply beat without tlast or with link_up set");

  // no byte may enter while the store is being replayed
  a_no_rx_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !in_tready)
    else $error("input open during payload replay");

  // the replay engine goes idle after the final payload beat
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> !out_tvalid)
    else $error("beat presented right after frame end");

  // only pushes that the queue can take
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("job pushed into full queue");
`endif

endmodule

// File: tb/deframer_beat_checker.sv
`timescale 1ns / 1ps

module deframer_beat_checker #(
  parameter int MAX_PAYLOAD  = 32,
  parameter int MAX_COMMANDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          error_count,
  output int          beats_owed
);
  import hcd_pkg::*;

  localparam logic KIND_REPLY   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    LINK_WAIT_FIRST,
    LINK_WAIT_THIRD,
    LINK_UP
  } link_phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [2:0] code;
    logic [4:0] pos;
    logic       last;
    logic       up;
  } beat_t;

  // register copies
  logic [7:0]  first_byte;
  logic [7:0]  reply_byte;
  logic [7:0]  third_byte;
  logic [3:0]  code_count;
  logic [47:0] length_table;

  // deframer state
  link_phase_t link_phase;
  logic        framing;
  logic [2:0]  frame_code;
  int          bytes_held;
  logic [7:0]  payload_buf [MAX_PAYLOAD];
  beat_t       expected_beats [$];

  initial begin
    error_count = 0;
    beats_owed  = 0;
  end

  // table length with zero and oversize entries clamped
  function automatic int frame_len(logic [2:0] code);
    int n;
    n = int'(length_table[6 * int'(code) +: 6]);
    if (n == 0) n = 1;
    if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
    return n;
  endfunction

  // expected beats caused by one received byte
  task automatic deframe_byte(logic [7:0] b);
    int limit;
    int len;
    case (link_phase)
      LINK_WAIT_FIRST: begin
        if (b == first_byte) begin
          link_phase = LINK_WAIT_THIRD;
          expected_beats.push_back('{KIND_REPLY, reply_byte, 3'd0, 5'd0, 1'b1, 1'b0});
        end
      end
      LINK_WAIT_THIRD: begin
        link_phase = (b == third_byte) ? LINK_UP : LINK_WAIT_FIRST;
      end
      default: begin
        if (!framing) begin
          limit = (int'(code_count) > MAX_COMMANDS) ? MAX_COMMANDS : int'(code_count);
          if (int'(b) < limit) begin
            frame_code = b[2:0];
            framing    = 1'b1;
            bytes_held = 0;
          end
        end else begin
          len = frame_len(frame_code);
          if (bytes_held < MAX_PAYLOAD) payload_buf[bytes_held] = b;
          bytes_held++;
          if (bytes_held >= len) begin
            for (int i = 0; i < len; i++) begin
              expected_beats.push_back('{KIND_PAYLOAD, payload_buf[i], frame_code,
                                         5'(i), logic'(i + 1 == len), 1'b1});
            end
            framing    = 1'b0;
            bytes_held = 0;
          end
        end
      end
    endcase
  endtask

  task automatic note_mismatch(string field, logic [7:0] want_v, logic [7:0] got_v);
    error_count++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
  endtask

  // compare one result beat with the oldest expectation
  task automatic check_beat();
    beat_t got;
    beat_t want;
    got = '{out_tuser, out_tdata[7:0], out_tdata[10:8], out_tdata[15:11],
            out_tlast, out_tdata[16]};
    if (expected_beats.size() == 0) begin
      error_count++;
      $display("%0t: unexpected result beat, expected none, got %p", $time, got);
    end else begin
      want = expected_beats.pop_front();
      if (got.kind !== want.kind) note_mismatch("kind", 8'(want.kind), 8'(got.kind));
      if (got.data !== want.data) note_mismatch("out_byte", want.data, got.data);
      if (got.code !== want.code) note_mismatch("cmd_code", 8'(want.code), 8'(got.code));
      if (got.pos !== want.pos) note_mismatch("byte_pos", 8'(want.pos), 8'(got.pos));
      if (got.last !== want.last) note_mismatch("last", 8'(want.last), 8'(got.last));
      if (got.up !== want.up) note_mismatch("link_up", 8'(want.up), 8'(got.up));
    end
  endtask

  // watch config writes and both streams
  always @(posedge clk) begin
    if (!rst_n) begin
      first_byte   = 8'd0;
      reply_byte   = 8'd0;
      third_byte   = 8'd0;
      code_count   = CMD_COUNT_RESET;
      length_table = 48'd0;
      link_phase   = LINK_WAIT_FIRST;
      framing      = 1'b0;
      frame_code   = 3'd0;
      bytes_held   = 0;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HS_FIRST:    first_byte   = cfg_wdata[7:0];
          CFG_HS_REPLY:    reply_byte   = cfg_wdata[7:0];
          CFG_HS_THIRD:    third_byte   = cfg_wdata[7:0];
          CFG_CMD_COUNT:   code_count   = cfg_wdata[3:0];
          CFG_CMD_LENGTHS: length_table = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_beat();
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
    end
    beats_owed = expected_beats.size();
  end

endmodule

// File: tb/handshake_command_deframer_tb.sv
`timescale 1ns / 1ps

module handshake_command_deframer_tb;
  import hcd_pkg::*;

  localparam int MAX_PAYLOAD  = 32;
  localparam int MAX_COMMANDS = 8;

  // register indexes with no register behind them
  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 14;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = 3'd0;
  logic [47:0] cfg_wdata  = 48'd0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int error_count;
  int beats_owed;

  int          tx_idle_pct  = 25;
  int          rx_idle_pct  = 82;
  bit          hold_request = 1'b0;
  bit          hold_taken   = 1'b0;
  int          hold_left    = 0;
  int          quiet_cycles = 0;
  int          code_limit   = MAX_COMMANDS;
  logic [47:0] len_table    = 48'd0;

  handshake_command_deframer #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MAX_COMMANDS(MAX_COMMANDS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  deframer_beat_checker #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MAX_COMMANDS(MAX_COMMANDS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .error_count(error_count),
    .beats_owed (beats_owed)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // register write, value in the low bits and random junk above
  task automatic write_reg(logic [2:0] idx, logic [47:0] value, int width);
    logic [47:0] junk;
    junk = 48'({$urandom, $urandom});
    junk = (junk >> width) << width;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= junk | value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // offer one byte, returns right after the accepting edge
  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering, drain every expected beat, let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (beats_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int payload_len(int code);
    int n;
    n = int'(len_table[6 * code +: 6]);
    if (n == 0) n = 1;
    if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
    return n;
  endfunction

  // mostly short entries, some zero, full and oversize
  function automatic logic [47:0] random_table();
    logic [47:0] t;
    int          r;
    for (int k = 0; k < NUM_CODES; k++) begin
      r = $urandom_range(9);
      if (r < 7) t[6 * k +: 6] = 6'($urandom_range(4, 1));
      else if (r == 7) t[6 * k +: 6] = 6'd0;
      else if (r == 8) t[6 * k +: 6] = 6'd32;
      else t[6 * k +: 6] = 6'($urandom_range(63, 33));
    end
    return t;
  endfunction

  task automatic configure(logic [3:0] count, logic [47:0] table_v);
    write_reg(CFG_HS_FIRST, 48'($urandom_range(255)), 8);
    write_reg(CFG_HS_REPLY, 48'($urandom_range(255)), 8);
    write_reg(CFG_HS_THIRD, 48'($urandom_range(255)), 8);
    write_reg(CFG_CMD_COUNT, 48'(count), 4);
    write_reg(CFG_CMD_LENGTHS, table_v, 48);
    write_reg(CFG_SPARE_LO, 48'hFFFF_FFFF_FFFF, 48);
    write_reg(CFG_SPARE_HI, 48'hFFFF_FFFF_FFFF, 48);
    code_limit = (int'(count) > MAX_COMMANDS) ? MAX_COMMANDS : int'(count);
    len_table  = table_v;
  endtask

  task automatic send_frame(int code);
    send_byte(8'(code));
    for (int i = 0; i < payload_len(code); i++) send_byte(8'($urandom_range(255)));
  endtask

  // random frames with dropped codes mixed in
  task automatic random_frames(int target);
    int sent;
    int code;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(1) == 0) send_byte(8'($urandom_range(15, code_limit)));
        else send_byte(8'($urandom_range(255, code_limit)));
      end else begin
        code = $urandom_range(code_limit - 1);
        if (payload_len(code) > 8 && $urandom_range(3) != 0) begin
          code = $urandom_range(code_limit - 1);
        end
        send_frame(code);
        sent += 1 + payload_len(code);
      end
    end
  endtask

  initial begin
    logic [47:0] t;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // handshake with reset registers: open, wrong third, stray byte
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h7F);
    settle();

    // wrong third byte equal to the opening byte, then a clean handshake
    write_reg(CFG_HS_FIRST, 48'hFF, 8);
    write_reg(CFG_HS_REPLY, 48'hFF, 8);
    write_reg(CFG_HS_THIRD, 48'h00, 8);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);

    // reset table: every frame one byte long, highest code valid
    send_byte(8'h07);
    send_byte(8'hAA);
    settle();

    // two codes: zero length entry, two byte entry; codes above dropped
    t        = 48'd0;
    t[5:0]   = 6'd0;
    t[11:6]  = 6'd2;
    t[17:12] = 6'd63;
    write_reg(CFG_CMD_COUNT, 48'd2, 4);
    write_reg(CFG_CMD_LENGTHS, t, 48);
    send_byte(8'h02);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h80);
    settle();

    // zero command count drops everything
    write_reg(CFG_CMD_COUNT, 48'd0, 4);
    send_byte(8'h00);
    settle();

    // random part, sender idles lightly and receiver heavily
    tx_idle_pct = 25;
    rx_idle_pct = 82;
    t = random_table();
    t[47:42] = 6'd63;
    configure(4'd8, t);
    random_frames(PHASE_BYTES);
    settle();

    // the other way round, count above the code range
    tx_idle_pct = 82;
    rx_idle_pct = 25;
    configure(4'd15, random_table());
    random_frames(PHASE_BYTES);
    settle();

    // no idling, long receiver hold-off behind a full frame
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    t = random_table();
    t[5:0] = 6'd32;
    configure(4'($urandom_range(MAX_COMMANDS, 1)), t);
    hold_request = 1'b1;
    send_frame(0);
    random_frames(PHASE_BYTES);
    settle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
